FILE: hw/rtl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants of the periodic client scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package pcs_pkg;
    localparam int MAX_CLIENTS = 16;
    localparam int ID_LIMIT    = 255;
    localparam int PB          = 16;
    localparam int IDX_W       = $clog2(MAX_CLIENTS);
    localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);
    localparam int EL_W        = 17;
    localparam logic [EL_W-1:0] EL_MAX = '1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_IDLIM = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    typedef struct packed {
        logic kind;
        logic [15:0] period;
        logic [15:0] tick_amount;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  client_id;
        logic        ready_valid;
        logic [15:0] optimal_period;
        logic [EL_W-1:0] elapsed_now;
        logic        last;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic find_step; // compare entry at scan index, advance
        logic shift_step;// move one entry up
        logic insert;    // write new entry, bump counters
        logic gcd_start;
        logic gcd_step;
        logic tick_upd;  // update elapsed time
        logic scan_start;// start modulo of entry at scan index
        logic mod_step;
        logic scan_next;
        logic emit_sel;  // 0: status result, 1: due client result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       is_tick;
        logic [1:0] reject;
        logic       empty;
        logic       find_done;
        logic       shift_done;
        logic       gcd_done;
        logic       mod_done;
        logic       mod_zero;
        logic       scan_end;
        logic       cap_hit;
    } t_sts;
endpackage
`default_nettype wire

FILE: hw/rtl/pcs_if.sv
// ----------------------------------------------------------------------------
// pcs_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
interface pcs_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/pcs_dp.sv
// ----------------------------------------------------------------------------
// pcs_dp
// Datapath: client table, counters, elapsed time, GCD and modulo unit.
// ----------------------------------------------------------------------------
`default_nettype none
module pcs_dp import pcs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in  i_item,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    output t_out      o_res
);
    logic [PB-1:0]    r_per [MAX_CLIENTS];
    logic [7:0]       r_id  [MAX_CLIENTS];
    logic [CNT_W-1:0] r_cnt;
    logic [7:0]       r_nid;
    logic [EL_W-1:0]  r_el;
    logic [PB-1:0]    r_gcd;
    logic             r_kind;
    logic [PB-1:0]    r_p;
    logic [15:0]      r_tick;
    logic [CNT_W-1:0] r_idx;   // insert position / scan index
    logic [CNT_W-1:0] r_sh;    // shift pointer
    logic [PB-1:0]    r_ga, r_gb;
    logic [EL_W-1:0]  r_rem;
    logic [EL_W-1:0]  r_div;
    logic [4:0]       r_nres;
    logic             r_added; // add item went into the table

    logic [IDX_W-1:0] w_ix, w_sh, w_shm1, w_last;
    logic [PB-1:0]    w_maxp;
    logic [EL_W:0]    w_e;
    logic [EL_W-1:0]  w_base;

    assign w_ix   = r_idx[IDX_W-1:0];
    assign w_sh   = r_sh[IDX_W-1:0];
    assign w_shm1 = IDX_W'(r_sh - 1'b1);
    assign w_last = IDX_W'(r_cnt - 1'b1);
    assign w_maxp = r_per[w_last];
    assign w_base = (r_el >= EL_W'(w_maxp)) ? r_el - EL_W'(w_maxp) : r_el;
    assign w_e    = {1'b0, w_base} + (EL_W+1)'(r_tick);

    always_comb begin
        o_sts.is_tick    = r_kind;
        o_sts.reject     = (r_nid >= 8'(ID_LIMIT)) ? ST_IDLIM :
                           (r_cnt >= CNT_W'(MAX_CLIENTS)) ? ST_FULL :
                           (r_p == '0) ? ST_ZERO : ST_OK;
        o_sts.empty      = (r_cnt == '0);
        o_sts.find_done  = (r_idx >= r_cnt) || (r_per[w_ix] > r_p);
        o_sts.shift_done = (r_sh <= r_idx);
        o_sts.gcd_done   = (r_gb == '0);
        o_sts.mod_done   = (r_rem < r_div);
        o_sts.mod_zero   = (r_rem == '0);
        o_sts.scan_end   = (r_idx >= r_cnt);
        o_sts.cap_hit    = (r_nres == 5'd16);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_item.kind;
            r_p     <= i_item.period[PB-1:0];
            r_tick  <= i_item.tick_amount;
            r_idx   <= '0;
            r_nres  <= '0;
            r_added <= 1'b0;
        end
        if (i_cmd.find_step) r_idx <= r_idx + 1'b1;
        if (i_cmd.shift_step) begin
            r_per[w_sh] <= r_per[w_shm1];
            r_id[w_sh]  <= r_id[w_shm1];
            r_sh        <= r_sh - 1'b1;
        end
        if (i_cmd.insert) begin
            r_per[w_ix] <= r_p;
            r_id[w_ix]  <= r_nid;
            r_added     <= 1'b1;
        end
        if (i_cmd.gcd_start) begin
            r_ga <= r_gcd;
            r_gb <= r_p;
        end
        if (i_cmd.gcd_step) begin
            // subtractive Euclid: subtract, or swap when a < b
            if (r_ga >= r_gb) r_ga <= r_ga - r_gb;
            else begin
                r_ga <= r_gb;
                r_gb <= r_ga;
            end
        end
        if (i_cmd.tick_upd) r_idx <= '0;
        if (i_cmd.scan_start) begin
            r_rem <= r_el;
            r_div <= EL_W'(r_per[w_ix]);
        end
        if (i_cmd.mod_step) r_rem <= r_rem - r_div;
        if (i_cmd.scan_next) r_idx <= r_idx + 1'b1;
        if (i_cmd.emit_sel) r_nres <= r_nres + 1'b1;
        if (i_cmd.find_step == 1'b0 && i_cmd.load) r_sh <= r_cnt;
        else if (i_cmd.find_step) r_sh <= r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_nid <= '0;
            r_el  <= '0;
            r_gcd <= '0;
        end else begin
            if (i_cmd.insert) begin
                r_cnt <= r_cnt + 1'b1;
                r_nid <= r_nid + 1'b1;
                if (r_gcd == '0) r_gcd <= r_p;
            end
            if (i_cmd.gcd_step && r_gb == '0) r_gcd <= r_ga;
            if (i_cmd.tick_upd)
                r_el <= w_e[EL_W] ? EL_MAX : w_e[EL_W-1:0];
        end
    end

    // counters have moved on by the time an accepted add reports, so the
    // accept flag picks the status, not a fresh check
    always_comb begin
        o_res.status         = ST_OK;
        o_res.client_id      = '0;
        o_res.ready_valid    = 1'b0;
        o_res.optimal_period = 16'(r_gcd);
        o_res.elapsed_now    = r_el;
        o_res.last           = 1'b1;
        if (i_cmd.emit_sel) begin
            o_res.client_id   = r_id[w_ix];
            o_res.ready_valid = 1'b1;
            o_res.last        = 1'b0;
        end else if (!r_kind) begin
            o_res.status    = r_added ? ST_OK : o_sts.reject;
            o_res.client_id = r_added ? 8'(r_nid - 1'b1) : 8'd0;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/pcs_ctrl.sv
// ----------------------------------------------------------------------------
// pcs_ctrl
// Controller: sequences add and tick items, drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module pcs_ctrl import pcs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire logic i_out_ready,
    output logic      o_out_valid,
    output t_out      o_out,
    input  wire t_sts i_sts,
    input  wire t_out i_res,
    output t_cmd      o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_FIND  = 4'd2;
    localparam logic [3:0] S_SHIFT = 4'd3;
    localparam logic [3:0] S_GCD   = 4'd4;
    localparam logic [3:0] S_AOUT  = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_MOD   = 4'd7;
    localparam logic [3:0] S_CHK   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_WAIT  = 4'd10;

    logic [3:0] r_st, n_st;
    logic       r_ov, r_hv, n_hv;
    t_out       r_out, r_hold, w_push_data;
    logic       w_push, w_free, w_take, w_from_hold;

    assign w_free      = !r_ov || i_out_ready;
    assign o_in_ready  = (r_st == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    always_comb begin
        n_st        = r_st;
        n_hv        = r_hv;
        o_cmd       = '0;
        w_push      = 1'b0;
        w_take      = 1'b0;
        w_from_hold = 1'b0;
        unique case (r_st)
            S_IDLE: if (i_in_valid) begin
                o_cmd.load = 1'b1;
                n_st = S_DEC;
            end
            S_DEC: begin
                if (!i_sts.is_tick) n_st = (i_sts.reject == ST_OK) ? S_FIND : S_AOUT;
                else if (i_sts.empty) n_st = S_AOUT;
                else begin
                    o_cmd.tick_upd = 1'b1;
                    n_st = S_SCAN;
                end
            end
            S_FIND: if (i_sts.find_done) n_st = S_SHIFT;
                    else o_cmd.find_step = 1'b1;
            S_SHIFT: if (i_sts.shift_done) begin
                o_cmd.insert = 1'b1;
                o_cmd.gcd_start = 1'b1;
                n_st = S_GCD;
            end else o_cmd.shift_step = 1'b1;
            S_GCD: begin
                o_cmd.gcd_step = 1'b1;
                if (i_sts.gcd_done) n_st = S_AOUT;
            end
            S_AOUT: if (w_free) begin
                w_push = 1'b1;
                n_st = S_WAIT;
            end
            S_SCAN: begin
                if (i_sts.scan_end || i_sts.cap_hit) n_st = S_FIN;
                else begin
                    o_cmd.scan_start = 1'b1;
                    n_st = S_MOD;
                end
            end
            S_MOD: begin
                if (i_sts.mod_done) n_st = S_CHK;
                else o_cmd.mod_step = 1'b1;
            end
            S_CHK: begin
                if (!i_sts.mod_zero) begin
                    o_cmd.scan_next = 1'b1;
                    n_st = S_SCAN;
                end else if (!r_hv || w_free) begin
                    // a newer due client frees the held one as not last
                    o_cmd.emit_sel = 1'b1;
                    o_cmd.scan_next = 1'b1;
                    w_take = 1'b1;
                    w_push = r_hv;
                    w_from_hold = r_hv;
                    n_hv = 1'b1;
                    n_st = S_SCAN;
                end
            end
            S_FIN: if (w_free) begin
                w_push = 1'b1;
                w_from_hold = r_hv;
                n_hv = 1'b0;
                n_st = S_WAIT;
            end
            S_WAIT: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // the held due result leaves as last only from FIN
    always_comb begin
        w_push_data = i_res;
        if (w_from_hold) begin
            w_push_data      = r_hold;
            w_push_data.last = (r_st == S_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
            r_hv <= 1'b0;
        end else begin
            r_st <= n_st;
            r_hv <= n_hv;
            if (w_push) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    // Due results are held one deep until the next due client or the end of
    // the scan tells whether the held one is last.
    always_ff @(posedge i_clk) begin
        if (w_push) r_out <= w_push_data;
        if (w_take) r_hold <= i_res;
    end
endmodule
`default_nettype wire

FILE: hw/rtl/periodic_client_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_client_scheduler
// Periodic client table with running GCD and due-client reporting on ticks.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                      Transfer when
// s_in      in   kind, period, tick_amount    valid && ready
// m_out     out  status..last (one or more)   valid && ready
//
// One item at a time: ready is high only while idle.
// Add: linear position search, one shift per cycle, then subtractive GCD.
// Tick: each entry checked by repeated subtraction of its period from the
// elapsed time.
// A due result is held until the next due client or the end of the scan
// so its last flag is known. Reset clears counters, GCD and elapsed time;
// the table needs no clearing. A stalled output holds the controller until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none
module periodic_client_scheduler import pcs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pcs_if.sink       s_in,
    pcs_if.source     m_out
);
    t_cmd w_cmd;
    t_sts w_sts;
    t_out w_res, w_out;
    t_in  w_item;
    logic w_ov;

    assign w_item = t_in'(s_in.data);

    pcs_dp u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (w_item),
        .i_cmd  (w_cmd),
        .o_sts  (w_sts),
        .o_res  (w_res)
    );

    pcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_in.valid),
        .o_in_ready (s_in.ready),
        .i_out_ready(m_out.ready),
        .o_out_valid(w_ov),
        .o_out      (w_out),
        .i_sts      (w_sts),
        .i_res      (w_res),
        .o_cmd      (w_cmd)
    );

    assign m_out.valid = w_ov;
    assign m_out.data  = w_out;
endmodule
`default_nettype wire

FILE: hw/rtl/pcs_chk.sv
// ----------------------------------------------------------------------------
// pcs_chk
// Port-level checks of the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
module pcs_chk import pcs_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic [$bits(t_out)-1:0] i_out_data
);
    t_out w_o;
    assign w_o = i_out_data;

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output changed under stall");
    a_due_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && w_o.ready_valid |-> w_o.status == ST_OK)
        else $error("due result with error status");
    a_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && w_o.status != ST_OK |-> w_o.client_id == 8'd0 && w_o.last)
        else $error("rejected add malformed");
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("accepted while busy");
endmodule

bind periodic_client_scheduler pcs_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (s_in.valid),
    .i_in_ready (s_in.ready),
    .i_out_valid(m_out.valid),
    .i_out_ready(m_out.ready),
    .i_out_data (m_out.data)
);
`default_nettype wire
